// File: rtl/assert_macros.svh
// Assertion macros shared by the RTL of the NTC thermistor temperature block.
// Depends on nothing; included by the files that check their own logic.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// A property that must hold at every clock edge outside reset.
`define ASSERT_ALWAYS(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error(msg);

// A consequent that must hold in the same cycle as its antecedent.
`define ASSERT_IMPLY(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

`endif

// File: rtl/ntc_pkg.sv
// Shared types, constants and resistance tables of the NTC thermistor block.
// Depends on nothing; used by every RTL module of the block.
package ntc_pkg;

    localparam int unsigned LAST_INDEX_STD = 140;
    localparam int unsigned LAST_INDEX_ALT = 179;
    localparam int unsigned ADC_FULL_SCALE = 4095;

    localparam int unsigned CODE_W   = 12;
    localparam int unsigned SERIES_W = 24;
    localparam int unsigned ENTRY_W  = 24;
    localparam int unsigned TEMP_W   = 9;
    localparam int unsigned STATUS_W = 2;
    localparam int unsigned CFG_IDX_W  = 1;
    localparam int unsigned CFG_DATA_W = 24;

    localparam int unsigned STD_SIZE = 141;
    localparam int unsigned ALT_SIZE = 180;
    localparam int unsigned STD_LAST = (LAST_INDEX_STD > STD_SIZE - 1) ?
                                       STD_SIZE - 1 : LAST_INDEX_STD;
    localparam int unsigned ALT_LAST = (LAST_INDEX_ALT > ALT_SIZE - 1) ?
                                       ALT_SIZE - 1 : LAST_INDEX_ALT;

    localparam int unsigned MAX_SIZE = (STD_SIZE > ALT_SIZE) ? STD_SIZE : ALT_SIZE;
    localparam int unsigned IDX_W    = $clog2(MAX_SIZE + 1);

    localparam int unsigned FS_BITS = $clog2(ADC_FULL_SCALE + 1);
    localparam int unsigned FS_W    = (FS_BITS > CODE_W) ? FS_BITS : CODE_W;
    localparam int unsigned DEN_W   = FS_BITS;
    localparam int unsigned NUM_W   = SERIES_W + CODE_W;
    localparam int unsigned PROD_W  = ENTRY_W + DEN_W;
    localparam int unsigned CMP_W   = (NUM_W > PROD_W) ? NUM_W : PROD_W;

    localparam int unsigned TEMP_OFFSET = 30;

    localparam logic [STATUS_W-1:0] STATUS_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_SHORT = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_OPEN  = 2'd2;

    localparam logic [CFG_IDX_W-1:0] CFG_TABLE_SELECT = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_SERIES       = 1'b1;

    localparam logic [SERIES_W-1:0] SERIES_RESET = 24'd100000;

    typedef struct packed {
        logic                sel;
        logic [STATUS_W-1:0] status;
        logic [NUM_W-1:0]    num;
        logic [DEN_W-1:0]    den;
        logic [IDX_W-1:0]    cnt;
        logic                last_gt;
    } t_item;

    localparam logic [ENTRY_W-1:0] TAB_STD [STD_SIZE] = '{
        24'd1792666, 24'd1684053, 24'd1582726, 24'd1488151, 24'd1399837,
        24'd1317332, 24'd1240216, 24'd1168107, 24'd1100648, 24'd1037512,
        24'd978396, 24'd923020, 24'd871124, 24'd822471, 24'd776837,
        24'd734018, 24'd693823, 24'd656077, 24'd620616, 24'd587288,
        24'd555953, 24'd526480, 24'd498747, 24'd472643, 24'd448062,
        24'd424906, 24'd403086, 24'd382516, 24'd363117, 24'd344817,
        24'd327547, 24'd311243, 24'd295847, 24'd281301, 24'd267556,
        24'd254562, 24'd242274, 24'd230650, 24'd219650, 24'd209239,
        24'd199380, 24'd190041, 24'd181193, 24'd172807, 24'd164857,
        24'd157317, 24'd150164, 24'd143376, 24'd136933, 24'd130816,
        24'd125005, 24'd119485, 24'd114239, 24'd109252, 24'd104510,
        24'd100000, 24'd95709, 24'd91626, 24'd87738, 24'd84037,
        24'd80512, 24'd77154, 24'd73953, 24'd70903, 24'd67995,
        24'd65221, 24'd62576, 24'd60051, 24'd57642, 24'd55342,
        24'd53146, 24'd51049, 24'd49045, 24'd47130, 24'd45300,
        24'd43551, 24'd41878, 24'd40278, 24'd38748, 24'd37283,
        24'd35882, 24'd34540, 24'd33255, 24'd32025, 24'd30846,
        24'd29717, 24'd28635, 24'd27597, 24'd26603, 24'd25649,
        24'd24734, 24'd23856, 24'd23014, 24'd22206, 24'd21431,
        24'd20686, 24'd19970, 24'd19283, 24'd18623, 24'd17989,
        24'd17380, 24'd16794, 24'd16231, 24'd15689, 24'd15168,
        24'd14667, 24'd14185, 24'd13722, 24'd13275, 24'd12845,
        24'd12431, 24'd12033, 24'd11649, 24'd11279, 24'd10923,
        24'd10580, 24'd10249, 24'd9930, 24'd9623, 24'd9326,
        24'd9040, 24'd8764, 24'd8498, 24'd8241, 24'd7994,
        24'd7754, 24'd7523, 24'd7300, 24'd7085, 24'd6877,
        24'd6676, 24'd6482, 24'd6295, 24'd6113, 24'd5938,
        24'd5769, 24'd5605, 24'd5447, 24'd5293, 24'd5145,
        24'd5002
    };

    localparam logic [ENTRY_W-1:0] TAB_ALT [ALT_SIZE] = '{
        24'd9119977, 24'd8660101, 24'd8219230, 24'd7794510, 24'd7384196,
        24'd6987468, 24'd6604077, 24'd6234194, 24'd5878218, 24'd5536648,
        24'd5210003, 24'd4898737, 24'd4603197, 24'd4323588, 24'd4059971,
        24'd3812256, 24'd3580213, 24'd3363482, 24'd3161589, 24'd2973974,
        24'd2799999, 24'd2638976, 24'd2490181, 24'd2352865, 24'd2226276,
        24'd2144699, 24'd2034380, 24'd1930172, 24'd1831747, 24'd1738790,
        24'd1651000, 24'd1568085, 24'd1489771, 24'd1415792, 24'd1345901,
        24'd1279859, 24'd1217443, 24'd1158441, 24'd1102652, 24'd1049888,
        24'd999973, 24'd952737, 24'd908026, 24'd865690, 24'd825591,
        24'd787598, 24'd751590, 24'd717452, 24'd685070, 24'd654358,
        24'd625207, 24'd597532, 24'd571250, 24'd546283, 24'd522556,
        24'd500000, 24'd478551, 24'd458148, 24'd438733, 24'd420225,
        24'd402656, 24'd385896, 24'd369928, 24'd354710, 24'd340201,
        24'd326366, 24'd313169, 24'd300577, 24'd288558, 24'd277084,
        24'd266126, 24'd255660, 24'd245659, 24'd236101, 24'd226965,
        24'd218228, 24'd209872, 24'd201879, 24'd194230, 24'd186909,
        24'd179900, 24'd173189, 24'd166761, 24'd160604, 24'd154704,
        24'd149050, 24'd143631, 24'd138434, 24'd133451, 24'd128672,
        24'd124087, 24'd119687, 24'd115465, 24'd111412, 24'd107522,
        24'd103786, 24'd100197, 24'd96751, 24'd93440, 24'd90258,
        24'd87200, 24'd84260, 24'd81434, 24'd78717, 24'd76104,
        24'd73590, 24'd71172, 24'd68845, 24'd66606, 24'd64451,
        24'd62377, 24'd60379, 24'd58456, 24'd56603, 24'd54819,
        24'd53100, 24'd51444, 24'd49847, 24'd48309, 24'd46826,
        24'd45396, 24'd44017, 24'd42688, 24'd41405, 24'd40168,
        24'd38892, 24'd37755, 24'd36660, 24'd35603, 24'd34584,
        24'd33600, 24'd32650, 24'd31732, 24'd30844, 24'd29986,
        24'd29156, 24'd28353, 24'd27575, 24'd26822, 24'd26092,
        24'd25385, 24'd24700, 24'd24036, 24'd23392, 24'd22767,
        24'd22161, 24'd21573, 24'd21003, 24'd20449, 24'd19912,
        24'd19390, 24'd18884, 24'd18392, 24'd17914, 24'd17450,
        24'd17000, 24'd16563, 24'd16138, 24'd15725, 24'd15324,
        24'd14934, 24'd14556, 24'd14188, 24'd13831, 24'd13484,
        24'd13147, 24'd12820, 24'd12502, 24'd12193, 24'd11892,
        24'd11600, 24'd11317, 24'd11041, 24'd10774, 24'd10513,
        24'd10261, 24'd10015, 24'd9776, 24'd9544, 24'd9319
    };

    function automatic logic [IDX_W-1:0] last_index(input logic sel);
        last_index = sel ? IDX_W'(ALT_LAST) : IDX_W'(STD_LAST);
    endfunction

    function automatic logic [ENTRY_W-1:0] table_entry(input logic sel,
                                                       input logic [IDX_W-1:0] idx);
        logic [ENTRY_W-1:0] value;
        value = '0;
        if (sel) begin
            if (int'(idx) < ALT_SIZE) begin
                value = TAB_ALT[idx];
            end
        end else begin
            if (int'(idx) < STD_SIZE) begin
                value = TAB_STD[idx];
            end
        end
        table_entry = value;
    endfunction

endpackage

// File: rtl/ntc_front.sv
// Front stages: fault classification, divider cross-product terms and the
// check against the last table entry. Depends on ntc_pkg.
module ntc_front (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_en,
    input  logic                           i_valid,
    input  logic [ntc_pkg::CODE_W-1:0]     i_adc_code,
    input  logic                           i_table_select,
    input  logic [ntc_pkg::SERIES_W-1:0]   i_series,
    output logic                           o_valid,
    output ntc_pkg::t_item                 o_item
);

    localparam int unsigned FS_W   = ntc_pkg::FS_W;
    localparam int unsigned NUM_W  = ntc_pkg::NUM_W;
    localparam int unsigned DEN_W  = ntc_pkg::DEN_W;
    localparam int unsigned CMP_W  = ntc_pkg::CMP_W;
    localparam int unsigned PROD_W = ntc_pkg::PROD_W;

    logic                  r_valid1;
    ntc_pkg::t_item        r_item1;
    logic                  r_valid2;
    ntc_pkg::t_item        r_item2;
    ntc_pkg::t_item        n_item1;
    ntc_pkg::t_item        n_item2;
    logic [FS_W-1:0]       w_code;
    logic [FS_W-1:0]       w_den;
    logic [PROD_W-1:0]     w_prod;

    always_comb begin
        w_code         = FS_W'(i_adc_code);
        w_den          = FS_W'(ntc_pkg::ADC_FULL_SCALE) - w_code;
        n_item1.sel    = i_table_select;
        n_item1.num    = NUM_W'(i_series) * NUM_W'(i_adc_code);
        n_item1.den    = w_den[DEN_W-1:0];
        n_item1.cnt    = '0;
        n_item1.last_gt = 1'b0;
        if (i_adc_code == '0) begin
            n_item1.status = ntc_pkg::STATUS_SHORT;
        end else if (w_code >= FS_W'(ntc_pkg::ADC_FULL_SCALE)) begin
            n_item1.status = ntc_pkg::STATUS_OPEN;
        end else begin
            n_item1.status = ntc_pkg::STATUS_OK;
        end
    end

    always_comb begin
        w_prod  = PROD_W'(ntc_pkg::table_entry(r_item1.sel,
                                               ntc_pkg::last_index(r_item1.sel)))
                  * PROD_W'(r_item1.den);
        n_item2 = r_item1;
        n_item2.last_gt = CMP_W'(w_prod) > CMP_W'(r_item1.num);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid1 <= 1'b0;
            r_valid2 <= 1'b0;
        end else if (i_en) begin
            r_valid1 <= i_valid;
            r_valid2 <= r_valid1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_item1 <= n_item1;
            r_item2 <= n_item2;
        end
    end

    assign o_valid = r_valid2;
    assign o_item  = r_item2;

endmodule

// File: rtl/ntc_search_step.sv
// One bit of the pipelined binary search over the descending resistance
// table: a table read stage and a cross-multiply compare stage. Depends on ntc_pkg.
module ntc_search_step #(
    parameter int unsigned BIT = 0
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_en,
    input  logic           i_valid,
    input  ntc_pkg::t_item i_item,
    output logic           o_valid,
    output ntc_pkg::t_item o_item
);

    localparam int unsigned IW     = ntc_pkg::IDX_W;
    localparam int unsigned CMP_W  = ntc_pkg::CMP_W;
    localparam int unsigned PROD_W = ntc_pkg::PROD_W;

    logic                         r_valid_a;
    ntc_pkg::t_item               r_item_a;
    logic [IW-1:0]                r_probe;
    logic                         r_in_range;
    logic [ntc_pkg::ENTRY_W-1:0]  r_entry;
    logic                         r_valid_b;
    ntc_pkg::t_item               r_item_b;
    logic [IW-1:0]                w_probe;
    logic [IW-1:0]                w_idx;
    logic [PROD_W-1:0]            w_prod;
    ntc_pkg::t_item               n_item_b;

    always_comb begin
        w_probe = i_item.cnt | (IW'(1) << BIT);
        w_idx   = w_probe - IW'(1);
    end

    always_comb begin
        w_prod   = PROD_W'(r_entry) * PROD_W'(r_item_a.den);
        n_item_b = r_item_a;
        if (r_in_range && (CMP_W'(w_prod) >= CMP_W'(r_item_a.num))) begin
            n_item_b.cnt = r_probe;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid_a <= 1'b0;
            r_valid_b <= 1'b0;
        end else if (i_en) begin
            r_valid_a <= i_valid;
            r_valid_b <= r_valid_a;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_item_a   <= i_item;
            r_probe    <= w_probe;
            r_in_range <= w_idx <= ntc_pkg::last_index(i_item.sel);
            r_entry    <= ntc_pkg::table_entry(i_item.sel, w_idx);
            r_item_b   <= n_item_b;
        end
    end

    assign o_valid = r_valid_b;
    assign o_item  = r_item_b;

endmodule

// File: rtl/ntc_back.sv
// Final stage: turns the search count into degrees Celsius and holds the
// result transaction until it is taken. Depends on ntc_pkg.
module ntc_back (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_valid,
    input  ntc_pkg::t_item                      i_item,
    input  logic                                i_ready,
    output logic                                o_en,
    output logic                                o_valid,
    output logic signed [ntc_pkg::TEMP_W-1:0]   o_temperature,
    output logic [ntc_pkg::STATUS_W-1:0]        o_status
);

    localparam int unsigned TEMP_W = ntc_pkg::TEMP_W;

    logic                       r_valid;
    logic [TEMP_W-1:0]          r_temperature;
    logic [ntc_pkg::STATUS_W-1:0] r_status;
    logic [TEMP_W-1:0]          w_idx;
    logic [TEMP_W-1:0]          n_temperature;

    assign o_en = !r_valid || i_ready;

    always_comb begin
        if (i_item.cnt == '0) begin
            w_idx = '0;
        end else if (i_item.last_gt) begin
            w_idx = TEMP_W'(ntc_pkg::last_index(i_item.sel)) + TEMP_W'(1);
        end else begin
            w_idx = TEMP_W'(i_item.cnt) - TEMP_W'(1);
        end
        if (i_item.status != ntc_pkg::STATUS_OK) begin
            n_temperature = '1;
        end else begin
            n_temperature = w_idx - TEMP_W'(ntc_pkg::TEMP_OFFSET);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_en) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_en) begin
            r_temperature <= n_temperature;
            r_status      <= i_item.status;
        end
    end

    assign o_valid       = r_valid;
    assign o_temperature = $signed(r_temperature);
    assign o_status      = r_status;

endmodule

// File: rtl/ntc_thermistor_temperature.sv
// Converts one NTC divider ADC code per transaction into whole degrees
// Celsius by a pipelined binary search of a descending resistance table.
// A new transaction can be accepted every cycle while no result waits at the
// output, and it passes through two front stages, two stages for each of the
// eight search bits (table read, then cross-multiply and compare), and the
// output register. The whole pipeline advances together and holds while a
// result waits at the output, so the output handshake sets the rate.
// Configuration writes are accepted at any time and must only be issued
// while no transaction is in flight. Depends on ntc_pkg and assert_macros.svh.
`include "assert_macros.svh"

module ntc_thermistor_temperature (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_valid,
    output logic                                o_ready,
    input  logic [ntc_pkg::CODE_W-1:0]          i_adc_code,
    output logic                                o_valid,
    input  logic                                i_ready,
    output logic signed [ntc_pkg::TEMP_W-1:0]   o_temperature,
    output logic [ntc_pkg::STATUS_W-1:0]        o_status,
    input  logic                                i_cfg_valid,
    output logic                                o_cfg_ready,
    input  logic [ntc_pkg::CFG_IDX_W-1:0]       i_cfg_index,
    input  logic [ntc_pkg::CFG_DATA_W-1:0]      i_cfg_data
);

    localparam int unsigned STEPS = ntc_pkg::IDX_W;

    logic                           r_table_select;
    logic [ntc_pkg::SERIES_W-1:0]   r_series;
    logic                           w_en;
    logic                           w_valid [STEPS+1];
    ntc_pkg::t_item                 w_item  [STEPS+1];

    assign o_cfg_ready = 1'b1;
    assign o_ready     = w_en;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_table_select <= 1'b0;
            r_series       <= ntc_pkg::SERIES_RESET;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                ntc_pkg::CFG_TABLE_SELECT: r_table_select <= i_cfg_data[0];
                ntc_pkg::CFG_SERIES:       r_series <= i_cfg_data[ntc_pkg::SERIES_W-1:0];
                default: begin
                end
            endcase
        end
    end

    ntc_front u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_en           (w_en),
        .i_valid        (i_valid),
        .i_adc_code     (i_adc_code),
        .i_table_select (r_table_select),
        .i_series       (r_series),
        .o_valid        (w_valid[0]),
        .o_item         (w_item[0])
    );

    for (genvar k = 0; k < STEPS; k++) begin : g_step
        ntc_search_step #(
            .BIT (STEPS - 1 - k)
        ) u_step (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (w_en),
            .i_valid (w_valid[k]),
            .i_item  (w_item[k]),
            .o_valid (w_valid[k+1]),
            .o_item  (w_item[k+1])
        );
    end

    ntc_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (w_valid[STEPS]),
        .i_item        (w_item[STEPS]),
        .i_ready       (i_ready),
        .o_en          (w_en),
        .o_valid       (o_valid),
        .o_temperature (o_temperature),
        .o_status      (o_status)
    );

    `ASSERT_IMPLY(a_fault_temp, i_clk, i_rst_n, o_valid && (o_status != ntc_pkg::STATUS_OK), o_temperature == -9'sd1, "fault result without temperature -1")
    `ASSERT_IMPLY(a_ok_range, i_clk, i_rst_n, o_valid && (o_status == ntc_pkg::STATUS_OK), (o_temperature >= -9'sd30) && (o_temperature <= 9'sd150), "temperature out of range")
    `ASSERT_IMPLY(a_stall_hold, i_clk, i_rst_n, o_valid && !i_ready, !o_ready, "input taken while output stalled")

endmodule
